// ----- rtl/core/mris_pkg.sv -----
// Package for the mixed radix index stepper: opcodes, widths, shared types.
// No dependencies.
package mris_pkg;
  localparam int unsigned OFF_W   = 11;
  localparam int unsigned STEP_W  = 32;
  localparam int unsigned FLAT_W  = 61;
  localparam int unsigned NREGS   = 6;

  typedef enum logic [1:0] {
    OP_ADVANCE = 2'd0,
    OP_RECEDE  = 2'd1,
    OP_START   = 2'd2,
    OP_END     = 2'd3
  } op_t;

  localparam logic [2:0] REG_NUM_DIMS = 3'd0;

  typedef struct packed {
    logic [1:0]        op;
    logic [2:0]        dim_sel;
    logic [STEP_W-1:0] step_amount;
  } in_item_t;

  typedef struct packed {
    logic [OFF_W-1:0]  offset_0;
    logic [OFF_W-1:0]  offset_1;
    logic [OFF_W-1:0]  offset_2;
    logic [OFF_W-1:0]  offset_3;
    logic [OFF_W-1:0]  offset_4;
    logic [OFF_W-1:0]  offset_5;
    logic [FLAT_W-1:0] flat_index;
    logic              at_start;
    logic              at_end;
    logic              bad_dim;
  } out_item_t;

  // Control between sequencer and divider.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;
endpackage

// ----- rtl/core/mris_if.sv -----
// Valid/ready channel interface carrying one payload of type T.
// Depends on mris_pkg for the payload types used at instantiation.
interface mris_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/mixed_radix_index_stepper_top.sv -----
// Top level of the mixed radix index stepper: sequencer, offsets, flat index.
// Depends on mris_pkg, mris_if and mris_div.
//
// Use: configuration is written through cfg_we/cfg_index/cfg_wdata, register 0
// being the dimension count and registers 1 to 6 the sizes of dimensions 0 to 5.
// Writes are taken at any edge with cfg_we high but are meant for idle time.
// Each input transfer carries op, dim_sel and step_amount; each one gives
// exactly one result transfer holding all offsets, the row-major flat index and
// the at-start, at-end and bad-dimension flags, taken after the operation.
// Operation: an advance or recede walks the carry chain one dimension at a time
// through a shared bit-serial divider (33 shift steps and a one-cycle done strobe),
// one division for each dimension that carries or borrows. The flat index then
// takes one multiply-add step per used dimension, and a final step loads the result.
// Set-to-start, set-to-end and a bad dimension skip the step and divider states.
// One item is in flight at a time:
// in_ch.ready is low until the result has been taken, then the next cycle is free.
// A stalled receiver simply holds the result register; nothing is lost.
// Reset returns the offsets to the start position, the count to one and every
// size to one.
module mixed_radix_index_stepper_top #(
  parameter int unsigned MAX_DIMS   = 6,
  parameter int unsigned SIZE_WIDTH = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  mris_if.sink        in_ch,
  mris_if.source      out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_wdata
);
  import mris_pkg::*;

  localparam logic [10:0] SIZE_TOP = 11'(1 << SIZE_WIDTH);
  localparam logic [2:0]  NMAX     = 3'(MAX_DIMS);

  typedef enum logic [2:0] {
    S_IDLE, S_STEP, S_DIVW, S_FLAT, S_OUT
  } state_t;

  state_t      state_r;
  logic [2:0]  num_dims_r;
  logic [10:0] size_r [NREGS];
  logic [10:0] off_r [NREGS];
  logic [2:0]  n_r, d_r, fi_r;
  logic        recede_r, bad_r;
  logic [32:0] step_r;
  logic [60:0] flat_r;
  out_item_t   res_r;
  logic        out_valid_r;

  div_ctl_t    dctl;
  div_sts_t    dsts;
  logic [32:0] ddend, dquo;
  logic [10:0] ddvs, drem;

  function automatic logic [10:0] effs(input logic [10:0] s);
    if (s == 11'd0) return 11'd1;
    if (s > SIZE_TOP) return SIZE_TOP;
    return s;
  endfunction

  logic [2:0] n_now;
  always_comb begin
    n_now = num_dims_r;
    if (n_now == 3'd0) n_now = 3'd1;
    if (n_now > NMAX) n_now = NMAX;
  end

  // Current-dimension values for the step state.
  logic [10:0] s_d, cur_d;
  logic [33:0] v_sum, rem_b;
  assign s_d   = effs(size_r[d_r]);
  assign cur_d = off_r[d_r];
  assign v_sum = {1'b0, step_r} + {23'd0, cur_d};
  assign rem_b = {1'b0, step_r} - {23'd0, cur_d} + {23'd0, s_d} - 34'd1;

  // Divider operand: advance divides v, recede divides rem+s-1.
  assign ddvs  = s_d;
  assign ddend = recede_r ? rem_b[32:0] : v_sum[32:0];

  mris_div u_div (
    .clk(clk), .rst_n(rst_n), .ctl(dctl), .dividend(ddend), .divisor(ddvs),
    .sts(dsts), .quotient(dquo), .remainder(drem)
  );

  logic [10:0] fs;
  logic [71:0] prod;
  assign fs   = effs(size_r[fi_r]);
  assign prod = flat_r * fs;

  logic [10:0] bor_off;
  logic [43:0] need_s;
  assign need_s  = dquo[32:0] * s_d;
  assign bor_off = 11'({11'd0, cur_d} + need_s - {12'd0, step_r});

  logic st_f, en_f;
  always_comb begin
    st_f = 1'b1;
    en_f = 1'b1;
    for (int i = 0; i < NREGS; i++) begin
      if (3'(i) < n_r) begin
        if (off_r[i] != 11'd0) st_f = 1'b0;
        if (3'(i + 1) < n_r) begin
          if (off_r[i] != effs(size_r[i]) - 11'd1) en_f = 1'b0;
        end else if (off_r[i] != effs(size_r[i])) begin
          en_f = 1'b0;
        end
      end
    end
  end

  assign dctl.start   = (state_r == S_STEP) &&
                        (recede_r ? ({1'b0, step_r} > {23'd0, cur_d}) :
                                    (v_sum >= {23'd0, s_d})) && (d_r != 3'd0);
  assign in_ch.ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      num_dims_r  <= 3'd1;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NREGS; i++) begin
        size_r[i] <= 11'd1;
        off_r[i]  <= 11'd0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_NUM_DIMS) num_dims_r <= cfg_wdata[2:0];
        else if (cfg_index <= 3'(NREGS)) size_r[cfg_index - 3'd1] <= cfg_wdata;
      end
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            n_r      <= n_now;
            d_r      <= in_ch.data.dim_sel;
            step_r   <= {1'b0, in_ch.data.step_amount};
            recede_r <= (in_ch.data.op == OP_RECEDE);
            unique case (op_t'(in_ch.data.op))
              OP_ADVANCE, OP_RECEDE: begin
                if (in_ch.data.dim_sel >= n_now) begin
                  bad_r   <= 1'b1;
                  state_r <= S_FLAT;
                end else begin
                  bad_r   <= 1'b0;
                  state_r <= S_STEP;
                end
              end
              OP_START: begin
                bad_r   <= 1'b0;
                state_r <= S_FLAT;
                for (int i = 0; i < NREGS; i++)
                  if (3'(i) < n_now) off_r[i] <= 11'd0;
              end
              OP_END: begin
                bad_r   <= 1'b0;
                state_r <= S_FLAT;
                for (int i = 0; i < NREGS; i++) begin
                  if (3'(i + 1) < n_now) off_r[i] <= effs(size_r[i]) - 11'd1;
                  else if (3'(i + 1) == n_now) off_r[i] <= effs(size_r[i]);
                end
              end
              default: ;
            endcase
          end
          flat_r <= '0;
          fi_r   <= 3'd0;
        end
        S_STEP: begin
          if (dctl.start) begin
            state_r <= S_DIVW;
          end else begin
            state_r <= S_FLAT;
            if (!recede_r) begin
              if (v_sum < {23'd0, s_d}) off_r[d_r] <= v_sum[10:0];
              else begin
                for (int i = 0; i < NREGS; i++) begin
                  if (3'(i + 1) < n_r) off_r[i] <= effs(size_r[i]) - 11'd1;
                  else if (3'(i + 1) == n_r) off_r[i] <= effs(size_r[i]);
                end
              end
            end else begin
              if ({1'b0, step_r} <= {23'd0, cur_d}) off_r[d_r] <= 11'(cur_d - step_r[10:0]);
              else begin
                for (int i = 0; i < NREGS; i++)
                  if (3'(i) < n_r) off_r[i] <= 11'd0;
              end
            end
          end
        end
        S_DIVW: begin
          if (dsts.done) begin
            off_r[d_r] <= recede_r ? bor_off : drem;
            step_r     <= dquo;
            d_r        <= d_r - 3'd1;
            state_r    <= S_STEP;
          end
        end
        S_FLAT: begin
          if (fi_r < n_r) begin
            flat_r <= 61'(prod) + {50'd0, off_r[fi_r]};
            fi_r   <= fi_r + 3'd1;
          end else begin
            res_r.offset_0   <= (n_r > 3'd0) ? off_r[0] : 11'd0;
            res_r.offset_1   <= (n_r > 3'd1) ? off_r[1] : 11'd0;
            res_r.offset_2   <= (n_r > 3'd2) ? off_r[2] : 11'd0;
            res_r.offset_3   <= (n_r > 3'd3) ? off_r[3] : 11'd0;
            res_r.offset_4   <= (n_r > 3'd4) ? off_r[4] : 11'd0;
            res_r.offset_5   <= (n_r > 3'd5) ? off_r[5] : 11'd0;
            res_r.flat_index <= flat_r;
            res_r.at_start   <= st_f;
            res_r.at_end     <= en_f;
            res_r.bad_dim    <= bad_r;
            out_valid_r      <= 1'b1;
            state_r          <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_valid_r && out_ch.ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The sequencer never accepts a transfer while a result is pending.
  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_ch.ready) else $error("accept while result pending");
  // The divider is only started when idle.
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    dctl.start |-> !dsts.busy) else $error("divider restarted while busy");
  // Waiting on the divider implies it is running or just finished.
  a_divw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVW) |-> (dsts.busy || dsts.done)) else $error("divider lost");
endmodule

// ----- rtl/core/mris_div.sv -----
// Restoring radix-2 divider: 33-bit dividend by 11-bit divisor, one bit per cycle.
// Depends on mris_pkg.
module mris_div (
  input  logic               clk,
  input  logic               rst_n,
  input  mris_pkg::div_ctl_t ctl,
  input  logic [32:0]        dividend,
  input  logic [10:0]        divisor,
  output mris_pkg::div_sts_t sts,
  output logic [32:0]        quotient,
  output logic [10:0]        remainder
);
  import mris_pkg::*;

  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0] q_r, q_nxt;
  logic [11:0] rem_r, rem_nxt;
  logic [10:0] dvs_r, dvs_nxt;
  logic [11:0] trial;

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r[10:0], q_r[32]};
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd33;
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      q_nxt = {q_r[31:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt  = trial - {1'b0, dvs_r};
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r[10:0];
endmodule
